[rtl/zmpr_pkg.sv]
// Shared types, constants and helpers for the midpoint ramp generator.
// No dependencies; every rtl file imports this package.
package zmpr_pkg;

    localparam int SAMPLES_DEF   = 32;
    localparam int MAX_STEPS_DEF = 16;

    // bits of the quotient of one ramp division (|d| < 2**24)
    localparam int QB = 24;

    // configuration register indexes
    localparam logic [0:0] CFG_HORIZON    = 1'b0;
    localparam logic [0:0] CFG_FIRST_STEP = 1'b1;

    typedef enum logic [1:0] {
        CMD_LEFT  = 2'd0,
        CMD_RIGHT = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_RUN   = 2'd3
    } t_zmpr_cmd;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         entry_index;
        logic [4:0]         step_count;
        logic [31:0]        start_time;
        logic [31:0]        end_time;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [19:0] pose_theta;
    } t_zmpr_in;

    typedef struct packed {
        logic [5:0]         sample_index;
        logic signed [23:0] mid_x;
        logic signed [23:0] mid_y;
        logic signed [19:0] mid_theta;
        logic               last;
    } t_zmpr_out;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [19:0] th;
    } t_zmpr_pose;

    // classified transaction held in the queue
    typedef struct packed {
        t_zmpr_cmd   kind;
        logic [3:0]  slot;
        logic [4:0]  nsteps;
        logic [31:0] t_a;
        logic [31:0] t_b;
        t_zmpr_pose  pose;
    } t_zmpr_op;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_zmpr_op op;
    } t_zmpr_q;

    // one footstep table entry
    typedef struct packed {
        logic [31:0] support_start;
        logic [31:0] t_end;
        t_zmpr_pose  pose;
    } t_zmpr_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SAMPLE,
        ST_RD,
        ST_RAMP,
        ST_COMP,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_OUT
    } t_zmpr_state;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_DIV
    } t_zmpr_mode;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] a);
        logic signed [23:0] r;
        if (a > 32'sd8388607)       r = 24'sh7FFFFF;
        else if (a < -32'sd8388608) r = 24'sh800000;
        else                        r = a[23:0];
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [31:0] a);
        logic signed [19:0] r;
        if (a > 32'sd524287)       r = 20'sh7FFFF;
        else if (a < -32'sd524288) r = 20'sh80000;
        else                       r = a[19:0];
        return r;
    endfunction

endpackage

[rtl/zmpr_front.sv]
// Front end: decodes incoming transactions and buffers them in a two-entry queue.
// Depends on zmpr_pkg.
module zmpr_front import zmpr_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_zmpr_in i_in_data,
    output logic     o_in_stall,
    output t_zmpr_q  o_q,
    input  logic     i_pop
);

    t_zmpr_op   op;
    logic       keep;
    logic [4:0] n0;
    logic       push;

    t_zmpr_op   r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    // classify: clamp step count, drop loads to slots outside the table
    always_comb begin
        op.kind   = t_zmpr_cmd'(i_in_data.cmd);
        op.slot   = i_in_data.entry_index;
        n0        = (i_in_data.step_count == 5'd0) ? 5'd1 : i_in_data.step_count;
        op.nsteps = ({4'b0, n0} > 9'(MAX_STEPS)) ? 5'(MAX_STEPS) : n0;
        op.t_a    = i_in_data.start_time;
        op.t_b    = i_in_data.end_time;
        op.pose.x  = i_in_data.pose_x;
        op.pose.y  = i_in_data.pose_y;
        op.pose.th = i_in_data.pose_theta;
        keep = !((op.kind == CMD_LOAD) && ({5'b0, i_in_data.entry_index} >= 9'(MAX_STEPS)));
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall && keep;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push)  r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr] <= op;
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.op    = r_slot[r_rd];

endmodule

[rtl/zmpr_back.sv]
// Back end: executes queued transactions, holds foot poses and the footstep table,
// and evaluates the ramp sum per sample with a shared shift-subtract divider. Uses zmpr_pkg.
module zmpr_back import zmpr_pkg::*; #(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_zmpr_q     i_q,
    output logic        o_pop,
    input  logic [31:0] i_horizon_span,
    input  logic [31:0] i_first_step_duration,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_zmpr_out   o_out_data
);

    localparam int         AW       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [6:0] DIVC     = 7'(SAMPLES - 1);
    localparam logic [5:0] LAST_IDX = 6'(SAMPLES - 1);
    // reciprocal of the sample count minus one, Q0.32, never above 2**32 - 1
    localparam longint unsigned RECIP_W = (64'd1 << 32) / 64'(SAMPLES - 1);
    localparam logic [31:0] RECIP = (RECIP_W > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                              : 32'(RECIP_W);

    t_zmpr_state r_state, n_state;

    // footstep table
    t_zmpr_entry r_mem [MAX_STEPS];
    t_zmpr_entry r_mem_q;
    logic [AW+3:0] wext;
    logic [AW-1:0] w_addr;
    logic          mem_we;

    t_zmpr_pose r_left, r_right, r_mid, r_prev;
    logic [31:0] r_tk;
    logic [4:0]  r_n;
    logic [4:0]  r_k;
    logic [31:0] r_pq;
    logic [5:0]  r_pr;
    logic [63:0] r_hprod;
    logic [6:0]  r_prem;
    logic [31:0] r_qacc;
    logic [5:0]  r_racc;
    logic [5:0]  r_idx;
    logic [32:0] r_t;
    logic signed [31:0] r_acc [3];
    logic        r_first;
    logic [AW-1:0] r_j;
    logic [4:0]  r_nleft;
    logic signed [24:0] r_d [3];
    t_zmpr_mode  r_mode;
    logic [31:0] r_absdiff, r_absdur;
    logic [1:0]  r_c;
    logic [23:0] r_mag;
    logic        r_neg;
    logic [55:0] r_rem;
    logic [QB-1:0] r_quo;
    logic        r_out_valid;
    t_zmpr_out   r_out;

    // combinational helpers
    logic signed [24:0] sx, sy, ax, ay;
    logic signed [20:0] sth, ath;
    t_zmpr_pose  mid_c;
    logic [6:0]  prem_c;
    logic [31:0] t0, t1;
    logic signed [33:0] dur, ndur;
    logic signed [34:0] diff, ndiff;
    t_zmpr_mode  mode_c;
    logic [31:0] absdiff_c, absdur_c;
    t_zmpr_pose  endp, basep;
    logic signed [24:0] dv, ndv;
    logic        last_c, more;
    logic        fire;
    logic [6:0]  rs;
    logic        wrap;
    logic [55:0] sh;
    logic signed [31:0] qs;

    assign wext   = {{AW{1'b0}}, i_q.op.slot};
    assign w_addr = wext[AW-1:0];
    assign o_pop  = (r_state == ST_IDLE) && i_q.valid;
    assign mem_we = o_pop && (i_q.op.kind == CMD_LOAD);

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[w_addr] <= {i_q.op.t_a, i_q.op.t_b, i_q.op.pose};
        end
        r_mem_q <= r_mem[r_j];
    end

    // foot midpoint, truncated toward zero
    always_comb begin
        sx  = 25'(r_left.x) + 25'(r_right.x);
        sy  = 25'(r_left.y) + 25'(r_right.y);
        sth = 21'(r_left.th) + 21'(r_right.th);
        ax  = sx + {24'b0, sx[24]};
        ay  = sy + {24'b0, sy[24]};
        ath = sth + {20'b0, sth[20]};
        mid_c.x  = 24'(ax >>> 1);
        mid_c.y  = 24'(ay >>> 1);
        mid_c.th = 20'(ath >>> 1);
    end

    // horizon step: reciprocal estimate, remainder from the low bits (true value < 2*DIVC)
    assign prem_c = i_horizon_span[6:0] - 7'({7'b0, r_hprod[38:32]} * {7'b0, DIVC});

    // ramp classification against the current sample time
    always_comb begin
        t0    = r_first ? 32'd0 : r_mem_q.support_start;
        t1    = r_first ? i_first_step_duration : r_mem_q.t_end;
        dur   = $signed({2'b0, t1}) - $signed({2'b0, t0});
        diff  = $signed({2'b0, r_t}) - $signed({3'b0, t0});
        ndur  = -dur;
        ndiff = -diff;
        absdiff_c = diff[31:0];
        absdur_c  = dur[31:0];
        if (dur == 34'sd0) begin
            mode_c = (r_t >= {1'b0, t1}) ? MODE_FULL : MODE_ZERO;
        end else if (dur > 34'sd0) begin
            if (diff <= 35'sd0)              mode_c = MODE_ZERO;
            else if (diff >= 35'(dur))       mode_c = MODE_FULL;
            else                             mode_c = MODE_DIV;
        end else begin
            absdiff_c = ndiff[31:0];
            absdur_c  = ndur[31:0];
            if (diff >= 35'sd0)              mode_c = MODE_ZERO;
            else if (diff <= 35'(dur))       mode_c = MODE_FULL;
            else                             mode_c = MODE_DIV;
        end
        if (r_first) begin
            endp.x  = r_right.x;
            endp.y  = r_right.y;
            endp.th = 20'sd0;
            basep   = r_mid;
        end else begin
            endp  = r_mem_q.pose;
            basep = r_prev;
        end
    end

    // per-component helpers
    always_comb begin
        dv     = r_d[r_c];
        ndv    = -dv;
        last_c = (r_c == 2'd2);
        more   = r_first ? (r_nleft != 5'd0) : (r_nleft != 5'd1);
        fire   = !r_out_valid || !i_out_stall;
        rs     = {1'b0, r_racc} + {1'b0, r_pr};
        wrap   = (rs >= DIVC);
        sh     = {24'b0, r_absdur} << r_k;
        qs     = r_neg ? -$signed({8'b0, r_quo}) : $signed({8'b0, r_quo});
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid && (i_q.op.kind == CMD_RUN)) n_state = ST_PREP;
            end
            ST_PREP:   if (r_k == 5'd0) n_state = ST_SAMPLE;
            ST_SAMPLE: n_state = ST_RAMP;
            ST_RD:     n_state = ST_RAMP;
            ST_RAMP:   n_state = ST_COMP;
            ST_COMP: begin
                if ((r_mode == MODE_DIV) && (dv != 25'sd0)) n_state = ST_MUL;
                else if (last_c) n_state = more ? ST_RD : ST_OUT;
            end
            ST_MUL:    n_state = ST_DIV;
            ST_DIV:    if (r_k == 5'd0) n_state = ST_ADD;
            ST_ADD: begin
                if (last_c) n_state = more ? ST_RD : ST_OUT;
                else        n_state = ST_COMP;
            end
            ST_OUT: begin
                if (fire) n_state = (r_idx == LAST_IDX) ? ST_IDLE : ST_SAMPLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && (i_q.op.kind == CMD_LEFT))  r_left  <= i_q.op.pose;
            if (o_pop && (i_q.op.kind == CMD_RIGHT)) r_right <= i_q.op.pose;
            if ((r_state == ST_OUT) && fire) r_out_valid <= 1'b1;
            else if (!i_out_stall)            r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_tk   <= i_q.op.t_a;
                r_n    <= i_q.op.nsteps;
                r_mid  <= mid_c;
                r_k    <= 5'd2;
                r_pq   <= '0;
                r_pr   <= '0;
                r_qacc <= '0;
                r_racc <= '0;
                r_idx  <= '0;
            end
            ST_PREP: begin
                // multiply, take the estimate, then one correction step
                if (r_k == 5'd2) begin
                    r_hprod <= {32'b0, i_horizon_span} * {32'b0, RECIP};
                end else if (r_k == 5'd1) begin
                    r_pq   <= r_hprod[63:32];
                    r_prem <= prem_c;
                end else if (r_prem >= DIVC) begin
                    r_pq <= r_pq + 32'd1;
                    r_pr <= 6'(r_prem - DIVC);
                end else begin
                    r_pr <= r_prem[5:0];
                end
                r_k <= r_k - 5'd1;
            end
            ST_SAMPLE: begin
                r_t      <= {1'b0, r_tk} + {1'b0, r_qacc};
                r_acc[0] <= 32'(r_mid.x);
                r_acc[1] <= 32'(r_mid.y);
                r_acc[2] <= 32'(r_mid.th);
                r_first  <= 1'b1;
                r_j      <= '0;
                r_nleft  <= r_n - 5'd1;
                r_c      <= 2'd0;
            end
            ST_RAMP: begin
                r_mode    <= mode_c;
                r_absdiff <= absdiff_c;
                r_absdur  <= absdur_c;
                r_d[0]    <= 25'(endp.x) - 25'(basep.x);
                r_d[1]    <= 25'(endp.y) - 25'(basep.y);
                r_d[2]    <= r_first ? 25'sd0 : 25'(endp.th) - 25'(basep.th);
                r_prev    <= endp;
                r_c       <= 2'd0;
            end
            ST_COMP: begin
                if (r_mode == MODE_FULL) r_acc[r_c] <= r_acc[r_c] + 32'(dv);
                r_mag <= dv[24] ? ndv[23:0] : dv[23:0];
                r_neg <= dv[24];
            end
            ST_MUL: begin
                r_rem <= {32'b0, r_mag} * {24'b0, r_absdiff};
                r_quo <= '0;
                r_k   <= 5'(QB - 1);
            end
            ST_DIV: begin
                if (r_rem >= sh) begin
                    r_rem <= r_rem - sh;
                    r_quo <= r_quo | (QB'(1) << r_k);
                end
                r_k <= r_k - 5'd1;
            end
            ST_ADD: begin
                r_acc[r_c] <= r_acc[r_c] + qs;
            end
            ST_OUT: begin
                if (fire) begin
                    r_out.sample_index <= r_idx;
                    r_out.mid_x        <= sat24(r_acc[0]);
                    r_out.mid_y        <= sat24(r_acc[1]);
                    r_out.mid_theta    <= sat20(r_acc[2]);
                    r_out.last         <= (r_idx == LAST_IDX);
                    r_racc <= wrap ? 6'(rs - DIVC) : rs[5:0];
                    r_qacc <= r_qacc + r_pq + 32'(wrap);
                    r_idx  <= r_idx + 6'd1;
                end
            end
            default: begin
            end
        endcase

        // end of a ramp: advance to the next footstep
        if (((r_state == ST_COMP) && !((r_mode == MODE_DIV) && (dv != 25'sd0)))
            || (r_state == ST_ADD)) begin
            if (last_c) begin
                r_first <= 1'b0;
                r_c     <= 2'd0;
                if (!r_first) begin
                    r_j     <= r_j + AW'(1);
                    r_nleft <= r_nleft - 5'd1;
                end
            end else begin
                r_c <= r_c + 2'd1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/zmp_midpoint_ramp_generator_unit.sv]
// Top level: config registers, front-end queue and back-end ramp engine.
// Run: prepares the horizon step, then for each sample evaluates its ramps and emits it;
// the ramps are the first ramp plus one per footstep read from the table.
// Set-foot and load transactions are executed as they are popped in idle; up to two queue ahead.
// Each divided ramp component costs a multiply, 24 shift-subtract steps and an add.
// Synchronous active-low reset clears foot poses, queue and config (1.0 s, 0.5 s);
// the footstep table is not cleared and holds garbage until loaded.
module zmp_midpoint_ramp_generator_unit import zmpr_pkg::*; #(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_zmpr_in    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_zmpr_out   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_horizon;
    logic [31:0] r_first_dur;
    t_zmpr_q     q;
    logic        pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon   <= 32'd65536;
            r_first_dur <= 32'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HORIZON:    r_horizon   <= i_cfg_data;
                CFG_FIRST_STEP: r_first_dur <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    zmpr_front #(
        .MAX_STEPS(MAX_STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_q        (q),
        .i_pop      (pop)
    );

    zmpr_back #(
        .SAMPLES  (SAMPLES),
        .MAX_STEPS(MAX_STEPS)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q                   (q),
        .o_pop                 (pop),
        .i_horizon_span        (r_horizon),
        .i_first_step_duration (r_first_dur),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_data            (o_out_data)
    );

    // last flag marks exactly the final sample index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.sample_index == 6'(SAMPLES - 1)))
        else $error("last flag on wrong sample");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.sample_index != 6'(SAMPLES - 1)))
        else $error("final sample without last flag");

    // after a delivered non-final sample, an immediately valid output carries the next index or repeats it
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last) ##1 o_out_valid
        |-> (o_out_data.sample_index == $past(o_out_data.sample_index) + 6'd1)
        || (o_out_data.sample_index == $past(o_out_data.sample_index)))
        else $error("sample index out of order");

endmodule
